// ===== rtl/i2cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbs_pkg
// shared command codes and queue entry types for the i2c bit sequencer
// ----------------------------------------------------------------------------
package i2cbs_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STEP_W  = 5;   // holds 0..23, longest command
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned BIT_W   = 3;

  // command codes
  localparam logic [FUNC_W-1:0] CMD_START    = 3'd0;
  localparam logic [FUNC_W-1:0] CMD_STOP     = 3'd1;
  localparam logic [FUNC_W-1:0] CMD_SEND     = 3'd2;
  localparam logic [FUNC_W-1:0] CMD_RECV     = 3'd3;
  localparam logic [FUNC_W-1:0] CMD_SEND_ACK = 3'd4;
  localparam logic [FUNC_W-1:0] CMD_RECV_ACK = 3'd5;

  localparam logic [BIT_W-1:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] tx_byte;
    logic              ack_level;
    logic [BYTE_W-1:0] line_bits;
  } cmd_t;

  // front to queue
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmdq_wr_t;

  // queue to back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_rd_t;

endpackage

// ===== rtl/i2cbs_front.sv =====
// ----------------------------------------------------------------------------
// i2cbs_front
// accepts commands, drops unused codes, forwards the rest to the queue
// ----------------------------------------------------------------------------
module i2cbs_front import i2cbs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [BYTE_W-1:0]   in_tx_byte,
  input  logic                in_ack_level,
  input  logic [BYTE_W-1:0]   in_line_bits,
  input  logic                q_full,
  output cmdq_wr_t            q_wr
);

  logic known_func;
  logic full_r;

  always_comb begin
    unique case (in_func)
      CMD_START, CMD_STOP, CMD_SEND,
      CMD_RECV, CMD_SEND_ACK, CMD_RECV_ACK: known_func = 1'b1;
      default:                              known_func = 1'b0;
    endcase
  end

  // hold off while reset is applied so nothing is taken in that cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b1;
    end else begin
      full_r <= 1'b0;
    end
  end

  assign in_full = q_full | full_r;

  // unused codes are taken and dropped: no pin writes, state untouched
  assign q_wr.push          = in_push & ~in_full & known_func;
  assign q_wr.cmd.func      = in_func;
  assign q_wr.cmd.tx_byte   = in_tx_byte;
  assign q_wr.cmd.ack_level = in_ack_level;
  assign q_wr.cmd.line_bits = in_line_bits;

endmodule

// ===== rtl/i2cbs_cmd_q.sv =====
// ----------------------------------------------------------------------------
// i2cbs_cmd_q
// two-entry command queue between the front and the pin sequencer
// ----------------------------------------------------------------------------
module i2cbs_cmd_q import i2cbs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cmdq_wr_t q_wr,
  output logic     q_full,
  output cmdq_rd_t q_rd,
  input  logic     q_pop
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_pop;

  assign q_full     = (cnt_r == 2'd2);
  assign q_rd.valid = (cnt_r != 2'd0);
  assign q_rd.cmd   = ent_r[rd_ptr_r];
  assign do_pop     = q_pop & q_rd.valid;

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      ent_r[wr_ptr_r] <= q_wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (q_wr.push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({q_wr.push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/i2cbs_exec.sv =====
// ----------------------------------------------------------------------------
// i2cbs_exec
// pin sequencer: one pin write per unstalled cycle into a result register
// ----------------------------------------------------------------------------
module i2cbs_exec import i2cbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmdq_rd_t          q_rd,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic              out_scl_level,
  output logic              out_sda_level,
  output logic              out_sample_point,
  output logic              out_last,
  output logic [BYTE_W-1:0] out_rx_data
);

  typedef struct packed {
    logic               scl_wr;    // 1 writes scl, 0 writes sda
    logic               level;
    logic               sample;
    logic               last;
    logic [BYTE_W-1:0]  rx;
    logic [PHASE_W-1:0] ph_nxt;
    logic               bit_inc;
  } step_dec_t;

  logic               busy_r;
  logic [FUNC_W-1:0]  func_r;
  logic [BYTE_W-1:0]  tx_sh_r;
  logic               ack_r;
  logic [BYTE_W-1:0]  line_r;
  logic [STEP_W-1:0]  step_r;
  logic [PHASE_W-1:0] ph_r;
  logic [BIT_W-1:0]   bit_r;
  logic               scl_r;
  logic               sda_r;
  logic               out_valid_r;
  logic               sample_r;
  logic               last_r;
  logic [BYTE_W-1:0]  rx_r;

  step_dec_t dec;
  logic      step_en;
  logic      load;

  always_comb begin
    dec         = '0;
    dec.ph_nxt  = ph_r;
    unique case (func_r)
      CMD_START: begin
        dec.scl_wr = step_r[0];
        dec.level  = (step_r < 5'd2);
        dec.last   = (step_r == 5'd3);
      end
      CMD_STOP: begin
        dec.scl_wr = (step_r == 5'd1);
        dec.level  = (step_r != 5'd0);
        dec.last   = (step_r == 5'd2);
      end
      CMD_SEND: begin
        case (ph_r)
          2'd0: begin
            dec.level  = tx_sh_r[BYTE_W-1];
            dec.ph_nxt = 2'd1;
          end
          2'd1: begin
            dec.scl_wr = 1'b1;
            dec.level  = 1'b1;
            dec.ph_nxt = 2'd2;
          end
          default: begin
            dec.scl_wr  = 1'b1;
            dec.level   = 1'b0;
            dec.last    = (bit_r == LAST_BIT);
            dec.ph_nxt  = 2'd0;
            dec.bit_inc = 1'b1;
          end
        endcase
      end
      CMD_RECV: begin
        if (step_r == 5'd0) begin
          dec.level = 1'b1;     // release sda
        end else if (ph_r == 2'd0) begin
          dec.scl_wr = 1'b1;
          dec.level  = 1'b1;
          dec.sample = 1'b1;
          dec.ph_nxt = 2'd1;
        end else begin
          dec.scl_wr  = 1'b1;
          dec.level   = 1'b0;
          dec.last    = (bit_r == LAST_BIT);
          dec.rx      = (bit_r == LAST_BIT) ? line_r : '0;
          dec.ph_nxt  = 2'd0;
          dec.bit_inc = 1'b1;
        end
      end
      CMD_SEND_ACK: begin
        dec.scl_wr = (step_r != 5'd0);
        dec.level  = (step_r == 5'd0) ? ack_r : (step_r == 5'd1);
        dec.last   = (step_r == 5'd2);
      end
      CMD_RECV_ACK: begin
        dec.scl_wr = (step_r != 5'd0);
        dec.level  = (step_r != 5'd2);
        dec.sample = (step_r == 5'd1);
        dec.last   = (step_r == 5'd2);
        dec.rx     = (step_r == 5'd2) ? {{(BYTE_W-1){1'b0}}, line_r[BYTE_W-1]} : '0;
      end
      default: begin
        dec.last = 1'b1;
      end
    endcase
  end

  assign step_en = busy_r & (~out_valid_r | out_pop);
  assign load    = q_rd.valid & (~busy_r | (step_en & dec.last));
  assign q_pop   = load;

  always_ff @(posedge clk) begin
    if (load) begin
      func_r  <= q_rd.cmd.func;
      tx_sh_r <= q_rd.cmd.tx_byte;
      ack_r   <= q_rd.cmd.ack_level;
      line_r  <= q_rd.cmd.line_bits;
    end else if (step_en && dec.bit_inc) begin
      tx_sh_r <= {tx_sh_r[BYTE_W-2:0], 1'b0};
    end
    if (step_en) begin
      sample_r <= dec.sample;
      last_r   <= dec.last;
      rx_r     <= dec.rx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      ph_r        <= '0;
      bit_r       <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        step_r <= '0;
        ph_r   <= '0;
        bit_r  <= '0;
      end else if (step_en) begin
        busy_r <= ~dec.last;
        step_r <= step_r + 5'd1;
        ph_r   <= dec.ph_nxt;
        bit_r  <= bit_r + {{(BIT_W-1){1'b0}}, dec.bit_inc};
      end
      if (step_en) begin
        if (dec.scl_wr) begin
          scl_r <= dec.level;
        end else begin
          sda_r <= dec.level;
        end
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_empty        = ~out_valid_r;
  assign out_scl_level    = scl_r;
  assign out_sda_level    = sda_r;
  assign out_sample_point = sample_r;
  assign out_last         = last_r;
  assign out_rx_data      = rx_r;

endmodule

// ===== rtl/i2c_master_bit_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// i2c master pin sequencer: one command in, one transaction per pin write out
// ----------------------------------------------------------------------------
//
//  channel   handshake       payload
//  -------   -------------   ------------------------------------------------
//  in_       push / full     func, tx_byte, ack_level, line_bits
//  out_      empty / pop     scl_level, sda_level, sample_point, last, rx_data
//
//  - one pin write per cycle unless the result waits for pop: start 4, stop 3,
//    send byte 24, receive byte 17, send ack 3, receive ack 3 result
//    transactions; the load from the command queue overlaps the final
//    write of the previous command, so only a command that finds the
//    sequencer idle has a load step of its own before its first write
//  - unused func codes (6, 7) are taken and produce no transactions
//  - full stays high through reset and for the first cycle after it; reset
//    sets both kept pin levels high
//  - a two-entry command queue lets the input side run ahead while the
//    result register waits for pop
//
module i2c_master_bit_sequencer_core import i2cbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [BYTE_W-1:0] in_tx_byte,
  input  logic              in_ack_level,
  input  logic [BYTE_W-1:0] in_line_bits,
  output logic              out_empty,
  input  logic              out_pop,
  output logic              out_scl_level,
  output logic              out_sda_level,
  output logic              out_sample_point,
  output logic              out_last,
  output logic [BYTE_W-1:0] out_rx_data
);

  cmdq_wr_t q_wr;
  cmdq_rd_t q_rd;
  logic     q_full;
  logic     q_pop;

  // front: classify and forward commands
  i2cbs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_func      (in_func),
    .in_tx_byte   (in_tx_byte),
    .in_ack_level (in_ack_level),
    .in_line_bits (in_line_bits),
    .q_full       (q_full),
    .q_wr         (q_wr)
  );

  // decoupling queue
  i2cbs_cmd_q u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  // back end: pin write sequencer with result register
  i2cbs_exec u_exec (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_rd             (q_rd),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_scl_level    (out_scl_level),
    .out_sda_level    (out_sda_level),
    .out_sample_point (out_sample_point),
    .out_last         (out_last),
    .out_rx_data      (out_rx_data)
  );

endmodule

// ===== rtl/i2cbs_checker.sv =====
// ----------------------------------------------------------------------------
// i2cbs_checker
// port-level checks for the i2c bit sequencer, bound to the top level
// ----------------------------------------------------------------------------
module i2cbs_checker import i2cbs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input logic              out_scl_level,
  input logic              out_sda_level,
  input logic              out_sample_point,
  input logic              out_last,
  input logic [BYTE_W-1:0] out_rx_data
);

  // nothing is taken in right after a reset edge
  a_reset_full: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input open right after reset");

  // nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // a stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_scl_level)
      && $stable(out_sda_level) && $stable(out_last) && $stable(out_rx_data)))
    else $error("stalled result changed");

  // sampling only happens with scl released high
  a_sample_scl: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_sample_point) |-> out_scl_level)
    else $error("sample point with scl low");

  // received data only shows on the final write of a command
  a_rx_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_last) |-> (out_rx_data == '0))
    else $error("rx data on a non-final write");

endmodule

bind i2c_master_bit_sequencer_core i2cbs_checker u_i2cbs_checker (.*);
